@@ design/u8d_pkg.sv @@
// Shared types and constants of the UTF-8 stream decoder.
package u8d_pkg;

  localparam int unsigned CpW        = 21;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned PayloadW   = 7;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  localparam logic [CpW-1:0] MaxScalar   = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrLo      = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi      = 21'h00DFFF;
  localparam logic [CpW-1:0] ReplReset   = 21'h00005F;

  typedef enum logic [2:0] {
    ClsAscii,
    ClsCont,
    ClsLead2,
    ClsLead3,
    ClsLead4,
    ClsInvalid
  } u8d_class_e;

  typedef struct packed {
    u8d_class_e          cls;
    logic [PayloadW-1:0] payload;
    logic                eot;
  } u8d_item_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           replaced;
    logic           last;
  } u8d_result_t;

endpackage

@@ design/u8d_front.sv @@
// Front end: classifies each incoming byte and strips its marker bits.
module u8d_front (
  input  logic [7:0]         byte_value_i,
  input  logic               end_of_text_i,
  output u8d_pkg::u8d_item_t item_o
);
  import u8d_pkg::*;

  always_comb begin
    item_o.eot     = end_of_text_i;
    item_o.payload = byte_value_i[PayloadW-1:0];
    case (byte_value_i) inside
      [8'h00:8'h7F]: begin
        item_o.cls = ClsAscii;
      end
      [8'h80:8'hBF]: begin
        item_o.cls     = ClsCont;
        item_o.payload = {1'b0, byte_value_i[5:0]};
      end
      [8'hC0:8'hDF]: begin
        item_o.cls     = ClsLead2;
        item_o.payload = {2'b00, byte_value_i[4:0]};
      end
      [8'hE0:8'hEF]: begin
        item_o.cls     = ClsLead3;
        item_o.payload = {3'b000, byte_value_i[3:0]};
      end
      [8'hF0:8'hF7]: begin
        item_o.cls     = ClsLead4;
        item_o.payload = {4'b0000, byte_value_i[2:0]};
      end
      default: begin
        item_o.cls = ClsInvalid;
      end
    endcase
  end

endmodule

@@ design/u8d_queue.sv @@
// Two-entry queue of classified words between front and back end.
module u8d_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  u8d_pkg::u8d_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output u8d_pkg::u8d_item_t item_o
);
  import u8d_pkg::*;

  u8d_item_t            mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueCntW'(QueueDepth))
    else $error("queue count above depth");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || full_o) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count missed a push");

endmodule

@@ design/u8d_back.sv @@
// Back end: sequence state, range checks and the result register.
module u8d_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [u8d_pkg::CpW-1:0]   cfg_wdata_i,
  input  logic                      head_valid_i,
  input  u8d_pkg::u8d_item_t        head_i,
  output logic                      head_pop_o,
  output logic                      res_valid_o,
  output u8d_pkg::u8d_result_t      res_o,
  input  logic                      res_pop_i
);
  import u8d_pkg::*;

  logic [CpW-1:0] repl_q;
  logic [1:0]     rem_q, rem_d;
  logic [CpW-1:0] part_q, part_d;
  logic           out_valid_q, out_valid_d;
  u8d_result_t    out_q, out_d;
  logic           step;
  logic           emit;
  u8d_result_t    emit_res;
  logic [CpW-1:0] gathered;
  logic [1:0]     rem_next;
  logic           bad_value;

  assign step     = head_valid_i && (!out_valid_q || res_pop_i);
  assign gathered = {part_q[CpW-7:0], head_i.payload[5:0]};
  assign rem_next = rem_q - 2'd1;
  assign bad_value = (gathered > MaxScalar) || (gathered inside {[SurrLo:SurrHi]});

  always_comb begin
    rem_d      = rem_q;
    part_d     = part_q;
    head_pop_o = step;
    emit       = 1'b0;
    emit_res   = '{code_point: repl_q, replaced: 1'b1, last: head_i.eot};
    if (step) begin
      if (rem_q == 2'd0) begin
        part_d = '0;
        case (head_i.cls)
          ClsAscii: begin
            emit     = 1'b1;
            emit_res = '{code_point: CpW'(head_i.payload), replaced: 1'b0, last: head_i.eot};
          end
          ClsLead2, ClsLead3, ClsLead4: begin
            if (head_i.eot) begin
              emit = 1'b1;
            end else begin
              part_d = CpW'(head_i.payload);
              case (head_i.cls)
                ClsLead2: rem_d = 2'd1;
                ClsLead3: rem_d = 2'd2;
                default:  rem_d = 2'd3;
              endcase
            end
          end
          default: begin
            emit = 1'b1;
          end
        endcase
      end else if (head_i.cls != ClsCont) begin
        emit       = 1'b1;
        emit_res   = '{code_point: repl_q, replaced: 1'b1, last: 1'b0};
        rem_d      = 2'd0;
        part_d     = '0;
        head_pop_o = 1'b0;
      end else if (rem_next != 2'd0) begin
        if (head_i.eot) begin
          emit   = 1'b1;
          rem_d  = 2'd0;
          part_d = '0;
        end else begin
          rem_d  = rem_next;
          part_d = gathered;
        end
      end else begin
        emit   = 1'b1;
        rem_d  = 2'd0;
        part_d = '0;
        if (!bad_value) begin
          emit_res = '{code_point: gathered, replaced: 1'b0, last: head_i.eot};
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !res_pop_i;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_res;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q      <= ReplReset;
      rem_q       <= '0;
      part_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        repl_q <= cfg_wdata_i;
      end
      rem_q       <= rem_d;
      part_q      <= part_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  a_eot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && head_pop_o && head_i.eot) |=> (rem_q == 2'd0))
    else $error("sequence left open after end of text");
  a_valid_scalar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.replaced) |->
      ((out_q.code_point <= MaxScalar) &&
       ((out_q.code_point < SurrLo) || (out_q.code_point > SurrHi))))
    else $error("unreplaced result outside scalar range");
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q == 2'd0) |-> (part_q == '0))
    else $error("partial value kept while idle");
  a_retry_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !head_pop_o) |=> (rem_q == 2'd0 && head_valid_i))
    else $error("early terminator not retried from idle");

endmodule

@@ design/utf8_stream_decoder_core.sv @@
// Top level of the UTF-8 stream decoder: front end, word queue, back end.
// A byte is stored in the queue, and a result is then held in the result register.
// Throughput: one byte per cycle while full is low and results are popped; a byte that
// cuts a sequence short is retried from idle after its replacement result, so the queue may fill.
// Reset clears the sequence state, the queue and the result valid flag, and sets
// the replacement code point to underscore (0x5F).
module utf8_stream_decoder_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [u8d_pkg::CpW-1:0] cfg_wdata_i,
  input  logic                    push,
  output logic                    full,
  input  logic [7:0]              byte_value_i,
  input  logic                    end_of_text_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [u8d_pkg::CpW-1:0] code_point_o,
  output logic                    replaced_o,
  output logic                    last_o
);
  import u8d_pkg::*;

  u8d_item_t   in_item;
  u8d_item_t   head;
  logic        head_valid;
  logic        head_pop;
  logic        res_valid;
  u8d_result_t res;

  u8d_front u_front (
    .byte_value_i  (byte_value_i),
    .end_of_text_i (end_of_text_i),
    .item_o        (in_item)
  );

  u8d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item),
    .full_o  (full),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .item_o  (head)
  );

  u8d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_pop_i    (pop)
  );

  assign empty        = !res_valid;
  assign code_point_o = res.code_point;
  assign replaced_o   = res.replaced;
  assign last_o       = res.last;

endmodule

@@ bench/utf8_stream_decoder_core_tb.sv @@
// Testbench for utf8_stream_decoder_core: byte stimulus, decoded code point prediction and check.
module utf8_stream_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u8d_pkg::*;

  localparam int unsigned ResetCycles = 9;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned StallLimit  = 4000;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we      = 1'b0;
  logic [CpW-1:0]   cfg_wdata   = '0;
  logic             push        = 1'b0;
  logic             full;
  logic [ByteW-1:0] byte_value  = '0;
  logic             end_of_text = 1'b0;
  logic             empty;
  logic             pop         = 1'b0;
  logic [CpW-1:0]   code_point;
  logic             replaced;
  logic             last;

  logic             holding     = 1'b0;
  event             hold_start;

  int unsigned      send_idle_pct = 0;
  int unsigned      stall_pct     = 0;
  int unsigned      mismatch_count = 0;
  int unsigned      quiet_cycles   = 0;

  // decoder state mirrored by the predictor
  logic [CpW-1:0]   repl_cp  = ReplReset;
  logic [1:0]       seq_left = '0;
  logic [CpW-1:0]   acc      = '0;

  u8d_result_t      expected_words[$];
  logic [7:0]       text_q[$];

  utf8_stream_decoder_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .push          (push),
    .full          (full),
    .byte_value_i  (byte_value),
    .end_of_text_i (end_of_text),
    .empty         (empty),
    .pop           (pop),
    .code_point_o  (code_point),
    .replaced_o    (replaced),
    .last_o        (last)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void note_word(input logic [CpW-1:0] cp, input logic rep, input logic fin);
    u8d_result_t w;
    w.code_point = cp;
    w.replaced   = rep;
    w.last       = fin;
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic void decode_idle_byte(input logic [7:0] b, input logic eot);
    int unsigned len;
    if (b[7] == 1'b0) begin
      note_word(CpW'(b), 1'b0, eot);
    end else if (b[7:6] == 2'b10 || b >= 8'hF8) begin
      note_word(repl_cp, 1'b1, eot);
    end else begin
      len = b[5] ? (b[4] ? 4 : 3) : 2;
      if (eot) begin
        seq_left = '0;
        acc      = '0;
        note_word(repl_cp, 1'b1, 1'b1);
      end else begin
        seq_left = 2'(len - 1);
        acc      = CpW'(b & 8'((8'h80 >> len) - 1));
      end
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic eot);
    logic [CpW-1:0] v;
    if (seq_left == 0) begin
      acc = '0;
      decode_idle_byte(b, eot);
    end else if (b[7:6] != 2'b10) begin
      seq_left = '0;
      acc      = '0;
      note_word(repl_cp, 1'b1, 1'b0);
      decode_idle_byte(b, eot);
    end else begin
      v        = {acc[CpW-7:0], b[5:0]};
      acc      = v;
      seq_left = seq_left - 1'b1;
      if (seq_left != 0) begin
        if (eot) begin
          seq_left = '0;
          acc      = '0;
          note_word(repl_cp, 1'b1, 1'b1);
        end
      end else begin
        acc = '0;
        if (v > MaxScalar || (v inside {[SurrLo:SurrHi]})) begin
          note_word(repl_cp, 1'b1, eot);
        end else begin
          note_word(v, 1'b0, eot);
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [CpW-1:0] want,
                                 input logic [CpW-1:0] got);
    mismatch_count++;
    $display("%0t: %s: expected 'h%0h, got 'h%0h", $time, what, want, got);
  endtask

  task automatic check_word();
    u8d_result_t w;
    if (expected_words.size() == 0) begin
      report_mismatch("word with none expected, code_point", '0, code_point);
    end else begin
      w = expected_words.pop_front();
      if (code_point !== w.code_point) report_mismatch("code_point", w.code_point, code_point);
      if (replaced !== w.replaced) begin
        report_mismatch("replaced", CpW'(w.replaced), CpW'(replaced));
      end
      if (last !== w.last) report_mismatch("last", CpW'(w.last), CpW'(last));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) check_word();
      pop <= !holding && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial forever begin
    @(hold_start);
    holding <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    holding <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && !(push && !full) && !(pop && !empty)) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eot);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    byte_value  <= b;
    end_of_text <= eot;
    do @(posedge clk_i); while (full);
    decode_byte(b, eot);
  endtask

  task automatic send_text();
    int unsigned i;
    for (i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_replacement(input logic [CpW-1:0] cp);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= cp;
    @(posedge clk_i);
    cfg_we  <= 1'b0;
    repl_cp = cp;
  endtask

  function automatic void append_seq(input int unsigned cp, input int unsigned len,
                                     input int unsigned keep);
    int unsigned i;
    logic [7:0]  lead;
    lead = (len == 2) ? 8'hC0 : (len == 3) ? 8'hE0 : 8'hF0;
    text_q.insert(text_q.size(),
                  lead | 8'((cp >> (6 * (len - 1))) & ((32'h80 >> len) - 1)));
    for (i = 1; i < keep; i++) begin
      text_q.insert(text_q.size(), 8'h80 | 8'((cp >> (6 * (len - 1 - i))) & 32'h3F));
    end
  endfunction

  function automatic void append_char();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      text_q.insert(text_q.size(), 8'($urandom_range(0, 8'h7F)));
    end else if (pick < 45) begin
      append_seq($urandom_range(0, 'h7FF), 2, 2);
    end else if (pick < 60) begin
      if ($urandom_range(0, 9) == 0) append_seq($urandom_range(SurrLo, SurrHi), 3, 3);
      else append_seq($urandom_range(0, 'hFFFF), 3, 3);
    end else if (pick < 72) begin
      if ($urandom_range(0, 4) == 0) append_seq($urandom_range(0, 'h1FFFFF), 4, 4);
      else append_seq($urandom_range('h10000, MaxScalar), 4, 4);
    end else if (pick < 80) begin
      text_q.insert(text_q.size(), 8'($urandom_range(8'h80, 8'hBF)));
    end else if (pick < 85) begin
      text_q.insert(text_q.size(), 8'($urandom_range(8'hF8, 8'hFF)));
    end else if (pick < 93) begin
      len = $urandom_range(2, 4);
      append_seq($urandom_range(0, 'h1FFFFF), len, $urandom_range(1, len - 1));
    end else begin
      text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void build_text(input int unsigned min_bytes);
    int unsigned n;
    text_q.delete();
    if ($urandom_range(0, 9) == 0 && min_bytes == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 10);
      repeat (n) append_char();
      while (text_q.size() < min_bytes) append_char();
    end
  endfunction

  task automatic send_list(input logic [7:0] bytes[$], input int unsigned eot_mask);
    int unsigned i;
    for (i = 0; i < bytes.size(); i++) send_byte(bytes[i], eot_mask[i]);
  endtask

  task automatic test_single_bytes();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_list('{8'h00, 8'h7F, 8'h80, 8'hFF}, 32'b1000);
  endtask

  task automatic test_sequences();
    send_list('{8'hC0, 8'h80, 8'hE2, 8'h82, 8'hAC, 8'hF4, 8'h8F, 8'hBF, 8'hBF},
              32'b1_0000_0000);
  endtask

  task automatic test_out_of_range();
    send_list('{8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80}, 32'b100_0000);
  endtask

  task automatic test_cut_short();
    send_list('{8'hC3, 8'h41, 8'hE2, 8'h82, 8'hC3}, 32'b11000);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    build_text(24);
    -> hold_start;
    send_text();
  endtask

  task automatic test_random_text(input int unsigned n_bytes, input int unsigned s_idle,
                                  input int unsigned r_stall);
    int unsigned sent;
    send_idle_pct = s_idle;
    stall_pct     = r_stall;
    sent          = 0;
    while (sent < n_bytes) begin
      build_text(0);
      sent += text_q.size();
      send_text();
    end
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_bytes();
    test_sequences();
    test_out_of_range();
    test_cut_short();
    set_replacement(MaxScalar);
    test_cut_short();
    test_backpressure();
    test_random_text(185, 0, 0);
    set_replacement('0);
    test_random_text(185, 74, 0);
    set_replacement(CpW'($urandom_range(0, MaxScalar)));
    test_random_text(185, 0, 74);
    set_replacement(ReplReset);
    test_random_text(185, 28, 28);

    drain();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
